// ----- sv/fir_lowpass_filter_unit_macros.svh -----
// assertion macros for the fir lowpass filter checker
// clock aclk and active-low reset aresetn are taken from the enclosing scope
`ifndef FIR_LOWPASS_FILTER_UNIT_MACROS_SVH
`define FIR_LOWPASS_FILTER_UNIT_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define FLP_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// consequent checked in the cycle after the antecedent
`define FLP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/flp_pkg.sv -----
// shared types, widths and the q1.15 lowpass coefficient set
// no dependencies
package flp_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int COEF_W      = 16;
    localparam int COEF_IDX_W  = 6;
    localparam int MUL_W       = SAMPLE_W + COEF_W;
    localparam int ACC_W       = 38;
    localparam int GAIN_W      = 16;
    localparam int OUT_W       = 32;
    localparam int DATA_W      = 32;
    localparam int ADDR_W      = 3;
    localparam int COEF_COUNT  = 39;
    localparam int DEF_TAP_COUNT = 39;

    localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd1;
    localparam logic REG_GAIN = 1'b0;

    typedef struct packed {
        logic clear;
        logic accum;
    } mac_ctrl_t;

    typedef struct packed {
        logic gain_load;
    } scale_ctrl_t;

    function automatic logic signed [COEF_W-1:0] coef_q15(input logic [COEF_IDX_W-1:0] idx);
        logic signed [COEF_W-1:0] c;
        case (idx)
            6'd0, 6'd38:  c = 16'sd120;
            6'd1, 6'd37:  c = -16'sd108;
            6'd2, 6'd36:  c = -16'sd186;
            6'd3, 6'd35:  c = -16'sd308;
            6'd4, 6'd34:  c = -16'sd455;
            6'd5, 6'd33:  c = -16'sd602;
            6'd6, 6'd32:  c = -16'sd722;
            6'd7, 6'd31:  c = -16'sd783;
            6'd8, 6'd30:  c = -16'sd755;
            6'd9, 6'd29:  c = -16'sd612;
            6'd10, 6'd28: c = -16'sd338;
            6'd11, 6'd27: c = 16'sd70;
            6'd12, 6'd26: c = 16'sd599;
            6'd13, 6'd25: c = 16'sd1218;
            6'd14, 6'd24: c = 16'sd1884;
            6'd15, 6'd23: c = 16'sd2541;
            6'd16, 6'd22: c = 16'sd3132;
            6'd17, 6'd21: c = 16'sd3602;
            6'd18, 6'd20: c = 16'sd3903;
            6'd19:        c = 16'sd4007;
            default:      c = '0;
        endcase
        return c;
    endfunction

endpackage

// ----- sv/flp_tap_cell.sv -----
// one delay cell of the sample chain: holds one sample, passes it on when enabled
// depends on flp_pkg
module flp_tap_cell
    import flp_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       shift_en,
    input  logic signed [SAMPLE_W-1:0] sample_din,
    output logic signed [SAMPLE_W-1:0] sample_dout
);

    logic signed [SAMPLE_W-1:0] sample_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_reg <= '0;
        end else if (shift_en) begin
            sample_reg <= sample_din;
        end
    end

    assign sample_dout = sample_reg;

endmodule

// ----- sv/flp_mac_unit.sv -----
// shared multiply-accumulate fed by the tail of the sample chain
// depends on flp_pkg
module flp_mac_unit
    import flp_pkg::*;
(
    input  logic                       aclk,
    input  mac_ctrl_t                  ctrl,
    input  logic signed [SAMPLE_W-1:0] sample,
    input  logic signed [COEF_W-1:0]   coef,
    output logic signed [ACC_W-1:0]    acc
);

    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_next;
    logic signed [MUL_W-1:0] mul;

    always_comb begin
        mul      = sample * coef;
        acc_next = acc_reg;
        if (ctrl.clear) begin
            acc_next = '0;
        end else if (ctrl.accum) begin
            acc_next = acc_reg + ACC_W'(mul);
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
    end

    assign acc = acc_reg;

endmodule

// ----- sv/flp_scale_unit.sv -----
// output scaling: clamp, gain multiply (registered), times ten and saturate to 32 bits
// depends on flp_pkg
module flp_scale_unit
    import flp_pkg::*;
(
    input  logic                    aclk,
    input  scale_ctrl_t             ctrl,
    input  logic signed [ACC_W-1:0] acc,
    input  logic [GAIN_W-1:0]       gain,
    output logic signed [OUT_W-1:0] result
);

    localparam int CLAMP_W = OUT_W + 1;
    localparam int PROD_W  = CLAMP_W + GAIN_W + 1;
    localparam int X10_W   = PROD_W + 4;

    localparam logic signed [ACC_W-1:0] ACC_HI   = ACC_W'(64'sh0000_0000_8000_0000);
    localparam logic signed [ACC_W-1:0] ACC_LO   = ACC_W'(-64'sh0000_0000_8000_0000);
    localparam logic signed [X10_W-1:0] OUT_HI   = X10_W'(64'sh0000_0000_7FFF_FFFF);
    localparam logic signed [X10_W-1:0] OUT_LO   = X10_W'(-64'sh0000_0000_8000_0000);

    logic signed [CLAMP_W-1:0] clamped;
    logic signed [GAIN_W:0]    gain_s;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [PROD_W-1:0]  prod_next;
    logic signed [X10_W-1:0]   prod_wide;
    logic signed [X10_W-1:0]   x10;

    // any sum past +-2^31 saturates once gain is nonzero, so clamp before the multiply
    always_comb begin
        if (acc > ACC_HI) begin
            clamped = CLAMP_W'(ACC_HI);
        end else if (acc < ACC_LO) begin
            clamped = CLAMP_W'(ACC_LO);
        end else begin
            clamped = CLAMP_W'(acc);
        end
        gain_s    = signed'({1'b0, gain});
        prod_next = clamped * gain_s;
    end

    always_ff @(posedge aclk) begin
        if (ctrl.gain_load) begin
            prod_reg <= prod_next;
        end
    end

    always_comb begin
        prod_wide = X10_W'(prod_reg);
        x10       = (prod_wide <<< 3) + (prod_wide <<< 1);
        if (x10 > OUT_HI) begin
            result = OUT_W'(OUT_HI);
        end else if (x10 < OUT_LO) begin
            result = OUT_W'(OUT_LO);
        end else begin
            result = OUT_W'(x10);
        end
    end

endmodule

// ----- sv/fir_lowpass_filter_unit.sv -----
// 39-tap symmetric fir lowpass, q1.15 coefficients, gain register, saturated 32-bit output
// s_ stream in one signed 16-bit sample per beat, m_ stream out one 32-bit result per beat.
// apb register 0 (byte address 0): gain_scale, 16 bits unsigned, reset 1.
// each accepted sample shifts into a chain of TAP_COUNT delay cells (newest first).
// the chain then rotates once around itself, one step per cycle, and a single shared
// multiply-accumulate takes the sample leaving the tail with its coefficient.
// from the input beat to m_tvalid: the mac walk over all TAP_COUNT taps after the insert,
// then the registered gain multiply, then scale/saturate into the output register.
// a new sample is taken only after the last result has left the final stage, as the
// single mac unit walks the tap chain for each item; s_tready is high only between items.
// the output register holds a finished result while the next sample is accepted;
// if the receiver stalls, the following result waits in the final stage with s_tready low.
// reset (aresetn low, synchronous) clears the chain to zero, gain to 1, and drops m_tvalid.
// gain_scale is only to be written while no item is in flight.
module fir_lowpass_filter_unit
    import flp_pkg::*;
#(
    parameter int TAP_COUNT = DEF_TAP_COUNT
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [15:0]       s_tdata,      // [15:0] sample_in
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [31:0]       m_tdata,      // [31:0] filtered_out
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    localparam int CNT_W = (TAP_COUNT > 1) ? $clog2(TAP_COUNT) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(TAP_COUNT - 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_MAC   = 2'd1;
    localparam logic [1:0] ST_GAIN  = 2'd2;
    localparam logic [1:0] ST_SCALE = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [GAIN_W-1:0] gain_reg;
    logic             m_tvalid_reg, m_tvalid_next;
    logic [OUT_W-1:0] m_tdata_reg;

    logic             s_accept;
    logic             out_load;
    logic             shift_en;
    logic             cfg_write;
    mac_ctrl_t        mac_ctrl;
    scale_ctrl_t      scale_ctrl;

    logic signed [SAMPLE_W-1:0] chain [TAP_COUNT];
    logic signed [SAMPLE_W-1:0] chain_in;
    logic signed [ACC_W-1:0]    acc;
    logic signed [OUT_W-1:0]    result;
    logic signed [COEF_W-1:0]   coef;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;

    // ---------------- configuration port ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_GAIN);
    assign prdata    = (paddr[2] == REG_GAIN) ? DATA_W'(gain_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg <= GAIN_RESET;
        end else if (cfg_write) begin
            gain_reg <= pwdata[GAIN_W-1:0];
        end
    end

    // ---------------- sample chain ----------------
    // insert at the head on a beat, otherwise the tail wraps back to the head
    assign shift_en = s_accept || (state_reg == ST_MAC);
    assign chain_in = s_accept ? signed'(s_tdata) : chain[TAP_COUNT-1];

    for (genvar k = 0; k < TAP_COUNT; k++) begin : g_cell
        flp_tap_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .shift_en    (shift_en),
            .sample_din  ((k == 0) ? chain_in : chain[(k == 0) ? 0 : k - 1]),
            .sample_dout (chain[k])
        );
    end

    // ---------------- mac ----------------
    assign coef           = coef_q15(COEF_IDX_W'(cnt_reg));
    assign mac_ctrl.clear = s_accept;
    assign mac_ctrl.accum = (state_reg == ST_MAC);

    flp_mac_unit u_mac (
        .aclk   (aclk),
        .ctrl   (mac_ctrl),
        .sample (chain[TAP_COUNT-1]),
        .coef   (coef),
        .acc    (acc)
    );

    assign scale_ctrl.gain_load = (state_reg == ST_GAIN);

    flp_scale_unit u_scale (
        .aclk   (aclk),
        .ctrl   (scale_ctrl),
        .acc    (acc),
        .gain   (gain_reg),
        .result (result)
    );

    // ---------------- control ----------------
    assign out_load = (state_reg == ST_SCALE) && (!m_tvalid_reg || m_tready);

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    state_next = ST_MAC;
                    cnt_next   = CNT_LAST;
                end
            end
            ST_MAC: begin
                if (cnt_reg == '0) begin
                    state_next = ST_GAIN;
                end else begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            ST_GAIN: begin
                state_next = ST_SCALE;
            end
            ST_SCALE: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= result;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ----- sv/flp_checker.sv -----
// port-level checks for the fir lowpass filter, bound to the top level
// depends on fir_lowpass_filter_unit_macros.svh
`include "fir_lowpass_filter_unit_macros.svh"

module flp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    // a stalled result beat holds
    `FLP_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result beat changed while stalled")

    // one sample in flight: ready drops right after an input beat
    `FLP_ASSERT_NEXT(a_busy_after_in, s_tvalid && s_tready, !s_tready, "input accepted while busy")

    // a new result only comes out of the final stage, when input is closed
    `FLP_ASSERT_SAME(a_out_from_busy, $rose(m_tvalid), $past(!s_tready), "result appeared while idle")

    // after an input beat the result needs the whole tap walk, never the next cycle
    `FLP_ASSERT_NEXT(a_no_early_out, s_tvalid && s_tready && !m_tvalid, !m_tvalid, "result too early")

endmodule

bind fir_lowpass_filter_unit flp_checker u_flp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
